// ===== hdl/rsi_pkg.sv =====
package rsi_pkg;

    localparam int CoordW = 16;
    localparam int DiffW  = CoordW + 1;
    localparam int DirPW  = DiffW + CoordW;
    localparam int CrossW = 2 * DiffW;
    localparam int DenW   = CrossW;
    localparam int UnumW  = CrossW + 1;
    localparam int ProdW  = DenW + DiffW;
    localparam int QuotW  = CoordW;

    typedef struct packed {
        logic                      hit;
        logic signed [ProdW-1:0]   px;
        logic signed [ProdW-1:0]   py;
        logic signed [DenW-1:0]    den;
        logic signed [CoordW-1:0]  ax;
        logic signed [CoordW-1:0]  ay;
    } t_front;

endpackage

// ===== hdl/rsi_front.sv =====
module rsi_front
    import rsi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [CoordW-1:0] i_wall_ax,
    input  logic signed [CoordW-1:0] i_wall_ay,
    input  logic signed [CoordW-1:0] i_wall_bx,
    input  logic signed [CoordW-1:0] i_wall_by,
    input  logic signed [CoordW-1:0] i_ray_x,
    input  logic signed [CoordW-1:0] i_ray_y,
    input  logic signed [CoordW-1:0] i_dir_x,
    input  logic signed [CoordW-1:0] i_dir_y,
    output logic                     o_valid,
    output t_front                   o_data
);

    logic [3:0] r_v;

    logic signed [DiffW-1:0]  r_abx, r_aby, r_apx, r_apy, r_bax1, r_bay1;
    logic signed [CoordW-1:0] r_dx, r_dy, r_ax1, r_ay1;

    logic signed [DirPW-1:0]  r_m1, r_m2, r_m3, r_m4;
    logic signed [CrossW-1:0] r_m5, r_m6;
    logic signed [DiffW-1:0]  r_bax2, r_bay2;
    logic signed [CoordW-1:0] r_ax2, r_ay2;

    logic signed [DenW-1:0]   r_den, r_tnum;
    logic signed [UnumW-1:0]  r_unum;
    logic signed [DiffW-1:0]  r_bax3, r_bay3;
    logic signed [CoordW-1:0] r_ax3, r_ay3;

    t_front r_out;

    logic n_hit, n_t_ok, n_u_ok;
    logic signed [ProdW-1:0] n_px, n_py;

    always_comb begin
        n_t_ok = 1'b0;
        n_u_ok = 1'b0;
        if (!r_den[DenW-1]) begin
            n_t_ok = (r_tnum > 0) && (r_tnum < r_den);
            n_u_ok = (r_unum > 0);
        end else begin
            n_t_ok = (r_tnum < 0) && (r_tnum > r_den);
            n_u_ok = (r_unum < 0);
        end
        n_hit = (r_den != 0) && n_t_ok && n_u_ok;
        n_px  = r_tnum * r_bax3;
        n_py  = r_tnum * r_bay3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abx  <= DiffW'(i_wall_ax) - DiffW'(i_wall_bx);
            r_aby  <= DiffW'(i_wall_ay) - DiffW'(i_wall_by);
            r_apx  <= DiffW'(i_wall_ax) - DiffW'(i_ray_x);
            r_apy  <= DiffW'(i_wall_ay) - DiffW'(i_ray_y);
            r_bax1 <= DiffW'(i_wall_bx) - DiffW'(i_wall_ax);
            r_bay1 <= DiffW'(i_wall_by) - DiffW'(i_wall_ay);
            r_dx   <= i_dir_x;
            r_dy   <= i_dir_y;
            r_ax1  <= i_wall_ax;
            r_ay1  <= i_wall_ay;

            r_m1   <= r_aby * r_dx;
            r_m2   <= r_abx * r_dy;
            r_m3   <= r_apy * r_dx;
            r_m4   <= r_apx * r_dy;
            r_m5   <= r_aby * r_apx;
            r_m6   <= r_abx * r_apy;
            r_bax2 <= r_bax1;
            r_bay2 <= r_bay1;
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;

            r_den  <= DenW'(r_m1) - DenW'(r_m2);
            r_tnum <= DenW'(r_m3) - DenW'(r_m4);
            r_unum <= UnumW'(r_m5) - UnumW'(r_m6);
            r_bax3 <= r_bax2;
            r_bay3 <= r_bay2;
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;

            r_out.hit <= n_hit;
            r_out.px  <= n_px;
            r_out.py  <= n_py;
            r_out.den <= r_den;
            r_out.ax  <= r_ax3;
            r_out.ay  <= r_ay3;
        end
    end

    assign o_valid = r_v[3];
    assign o_data  = r_out;

endmodule

// ===== hdl/rsi_div.sv =====
module rsi_div
    import rsi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_front                   i_data,
    output logic                     o_valid,
    output logic                     o_hit,
    output logic signed [CoordW-1:0] o_hit_x,
    output logic signed [CoordW-1:0] o_hit_y
);

    localparam int Steps = QuotW;

    logic [Steps:0]            r_v;
    logic [ProdW-1:0]          r_rx  [0:Steps];
    logic [ProdW-1:0]          r_ry  [0:Steps];
    logic [QuotW-1:0]          r_qx  [0:Steps];
    logic [QuotW-1:0]          r_qy  [0:Steps];
    logic [DenW-1:0]           r_d   [0:Steps];
    logic                      r_nx  [0:Steps];
    logic                      r_ny  [0:Steps];
    logic                      r_hit [0:Steps];
    logic signed [CoordW-1:0]  r_ax  [0:Steps];
    logic signed [CoordW-1:0]  r_ay  [0:Steps];

    logic                      r_vo;
    logic                      r_hit_o;
    logic signed [CoordW-1:0]  r_hx, r_hy;

    logic [ProdW-1:0]          n_rx [0:Steps-1];
    logic [ProdW-1:0]          n_ry [0:Steps-1];
    logic [QuotW-1:0]          n_qx [0:Steps-1];
    logic [QuotW-1:0]          n_qy [0:Steps-1];
    logic [ProdW-1:0]          n_abs_px, n_abs_py;
    logic [DenW-1:0]           n_abs_den;
    logic signed [QuotW:0]     n_sqx, n_sqy;

    always_comb begin
        n_abs_px  = i_data.px[ProdW-1] ? ProdW'(-i_data.px) : ProdW'(i_data.px);
        n_abs_py  = i_data.py[ProdW-1] ? ProdW'(-i_data.py) : ProdW'(i_data.py);
        n_abs_den = i_data.den[DenW-1] ? DenW'(-i_data.den) : DenW'(i_data.den);
    end

    always_comb begin
        logic [ProdW-1:0] w;
        w = '0;
        for (int k = 0; k < Steps; k++) begin
            w       = ProdW'(r_d[k]) << (Steps - 1 - k);
            n_rx[k] = r_rx[k];
            n_ry[k] = r_ry[k];
            n_qx[k] = r_qx[k];
            n_qy[k] = r_qy[k];
            if (r_rx[k] >= w) begin
                n_rx[k] = r_rx[k] - w;
                n_qx[k][Steps-1-k] = 1'b1;
            end
            if (r_ry[k] >= w) begin
                n_ry[k] = r_ry[k] - w;
                n_qy[k][Steps-1-k] = 1'b1;
            end
        end
    end

    always_comb begin
        n_sqx = r_nx[Steps] ? -$signed({1'b0, r_qx[Steps]}) : $signed({1'b0, r_qx[Steps]});
        n_sqy = r_ny[Steps] ? -$signed({1'b0, r_qy[Steps]}) : $signed({1'b0, r_qy[Steps]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[Steps-1:0], i_valid};
            r_vo <= r_v[Steps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx[0]  <= n_abs_px;
            r_ry[0]  <= n_abs_py;
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
            r_d[0]   <= n_abs_den;
            r_nx[0]  <= i_data.px[ProdW-1] ^ i_data.den[DenW-1];
            r_ny[0]  <= i_data.py[ProdW-1] ^ i_data.den[DenW-1];
            r_hit[0] <= i_data.hit;
            r_ax[0]  <= i_data.ax;
            r_ay[0]  <= i_data.ay;
            for (int k = 0; k < Steps; k++) begin
                r_rx[k+1]  <= n_rx[k];
                r_ry[k+1]  <= n_ry[k];
                r_qx[k+1]  <= n_qx[k];
                r_qy[k+1]  <= n_qy[k];
                r_d[k+1]   <= r_d[k];
                r_nx[k+1]  <= r_nx[k];
                r_ny[k+1]  <= r_ny[k];
                r_hit[k+1] <= r_hit[k];
                r_ax[k+1]  <= r_ax[k];
                r_ay[k+1]  <= r_ay[k];
            end
            r_hit_o <= r_hit[Steps];
            r_hx    <= r_hit[Steps] ? CoordW'(r_ax[Steps] + n_sqx) : '0;
            r_hy    <= r_hit[Steps] ? CoordW'(r_ay[Steps] + n_sqy) : '0;
        end
    end

    assign o_valid = r_vo;
    assign o_hit   = r_hit_o;
    assign o_hit_x = r_hx;
    assign o_hit_y = r_hy;

endmodule

// ===== hdl/ray_segment_intersect.sv =====
// Ray against wall segment intersection test.
// Input channel: i_valid / o_stall carries one request: the wall endpoints
// (Q12.4), the ray origin (Q12.4) and the ray direction (Q2.14).
// Output channel: o_valid / i_stall returns one result per request:
// o_hit and the hit point o_hit_x, o_hit_y (Q12.4, zero on a miss).
// The pipeline has four stages of differences, products, cross sums and
// hit test with the t-scaled products, one stage of magnitudes, sixteen
// stages of a restoring divider (one quotient bit each) and the output
// register.
// Throughput is one request per cycle while i_stall does not hold a waiting result; the divider is fully pipelined.
// Results leave in request order.
// Reset clears all valid bits; no result is pending after reset.
// While a result waits in the output register and i_stall is high, the
// whole pipeline holds and o_stall is raised; nothing is lost or repeated.
module ray_segment_intersect
    import rsi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [CoordW-1:0] i_wall_ax,
    input  logic signed [CoordW-1:0] i_wall_ay,
    input  logic signed [CoordW-1:0] i_wall_bx,
    input  logic signed [CoordW-1:0] i_wall_by,
    input  logic signed [CoordW-1:0] i_ray_x,
    input  logic signed [CoordW-1:0] i_ray_y,
    input  logic signed [CoordW-1:0] i_dir_x,
    input  logic signed [CoordW-1:0] i_dir_y,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_hit,
    output logic signed [CoordW-1:0] o_hit_x,
    output logic signed [CoordW-1:0] o_hit_y
);

    logic   en;
    logic   front_valid;
    t_front front_data;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    rsi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_wall_ax (i_wall_ax),
        .i_wall_ay (i_wall_ay),
        .i_wall_bx (i_wall_bx),
        .i_wall_by (i_wall_by),
        .i_ray_x   (i_ray_x),
        .i_ray_y   (i_ray_y),
        .i_dir_x   (i_dir_x),
        .i_dir_y   (i_dir_y),
        .o_valid   (front_valid),
        .o_data    (front_data)
    );

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_data  (front_data),
        .o_valid (o_valid),
        .o_hit   (o_hit),
        .o_hit_x (o_hit_x),
        .o_hit_y (o_hit_y)
    );

endmodule

// ===== hdl/rsi_checker.sv =====
module rsi_checker
    import rsi_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic                     o_hit,
    input logic signed [CoordW-1:0] o_hit_x,
    input logic signed [CoordW-1:0] o_hit_y
);

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_x == 0 && o_hit_y == 0))
        else $error("miss result with nonzero point");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_hit) && $stable(o_hit_x) && $stable(o_hit_y)))
        else $error("stalled result changed");

endmodule

bind ray_segment_intersect rsi_checker u_rsi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_hit   (o_hit),
    .o_hit_x (o_hit_x),
    .o_hit_y (o_hit_y)
);
